[design/spc_pkg.sv]
// shared types and constants for the sphere pair contact block
package spc_pkg;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW = 31;
  localparam int unsigned GapW = 35;
  localparam int unsigned NormW = 18;
  localparam int unsigned DiffW = 33;
  localparam int unsigned SqW = 68;
  localparam int unsigned DistW = 34;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [0:0] {
    REG_RADIUS_ONE = 1'b0,
    REG_RADIUS_TWO = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_ROOT, S_DIV, S_OUT} st_e;

  typedef struct packed {
    logic signed [CoordW-1:0] c1x, c1y, c1z, c2x, c2y, c2z;
  } item_t;
endpackage

[design/sphere_pair_contact.sv]
// top level of the sphere pair contact block
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+----------------------------
//  input    | start_i / busy_o              | center_one_*, center_two_*
//  config   | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//  result   | done_o (one-cycle strobe)     | gap, contact_*, normal_*, degenerate
//
// an input beat is taken whenever start_i is high and busy_o is low
// input beats go straight into a four-entry queue ahead of the back unit
// back unit takes one item at a time, through load, squares, root bits, divide bits and out
// done_o strobes once per item, together with that item's registered results
// reset sets both radii to 65536 (1.0 with the default 16 fraction bits) and empties queue and back unit
// the receiver cannot stall; busy_o is high only while the queue holds four items
module sphere_pair_contact #(
  parameter int unsigned FRACTION_BITS = spc_pkg::FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  logic signed [spc_pkg::CoordW-1:0] center_one_x_i,
  input  logic signed [spc_pkg::CoordW-1:0] center_one_y_i,
  input  logic signed [spc_pkg::CoordW-1:0] center_one_z_i,
  input  logic signed [spc_pkg::CoordW-1:0] center_two_x_i,
  input  logic signed [spc_pkg::CoordW-1:0] center_two_y_i,
  input  logic signed [spc_pkg::CoordW-1:0] center_two_z_i,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [spc_pkg::CoordW-1:0] cfg_data_i,
  output logic done_o,
  output logic signed [spc_pkg::GapW-1:0] gap_o,
  output logic signed [spc_pkg::CoordW-1:0] contact_x_o,
  output logic signed [spc_pkg::CoordW-1:0] contact_y_o,
  output logic signed [spc_pkg::CoordW-1:0] contact_z_o,
  output logic signed [spc_pkg::NormW-1:0] normal_x_o,
  output logic signed [spc_pkg::NormW-1:0] normal_y_o,
  output logic signed [spc_pkg::NormW-1:0] normal_z_o,
  output logic degenerate_o
);
  import spc_pkg::*;

  logic [RadW-1:0] r1_q, r2_q;
  item_t in_item, q_item;
  logic q_valid, q_pop, q_full;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_q <= RadW'(65536);
      r2_q <= RadW'(65536);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RADIUS_ONE: r1_q <= cfg_data_i[RadW-1:0];
        REG_RADIUS_TWO: r2_q <= cfg_data_i[RadW-1:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{center_one_x_i, center_one_y_i, center_one_z_i,
                     center_two_x_i, center_two_y_i, center_two_z_i};
  assign busy_o = q_full;

  spc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(start_i && !q_full), .item_i(in_item), .full_o(q_full),
    .valid_o(q_valid), .pop_i(q_pop), .item_o(q_item)
  );

  spc_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .pop_o(q_pop), .item_i(q_item),
    .r1_i(r1_q), .r2_i(r2_q),
    .done_o, .gap_o, .contact_x_o, .contact_y_o, .contact_z_o,
    .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );
endmodule

[design/spc_queue.sv]
// small fifo between front and back
module spc_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  spc_pkg::item_t item_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output spc_pkg::item_t item_o
);
  import spc_pkg::*;
  localparam int unsigned AW = $clog2(QueueDepth);
  item_t mem_q [QueueDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;

  assign full_o = cnt_q == (AW+1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign item_o = mem_q[rp_q];

  always_ff @(posedge clk_i) if (push_i) mem_q[wp_q] <= item_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule

[design/spc_back.sv]
// back unit: square root, divisions and result register
module spc_back #(
  parameter int unsigned FRACTION_BITS = spc_pkg::FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic pop_o,
  input  spc_pkg::item_t item_i,
  input  logic [spc_pkg::RadW-1:0] r1_i,
  input  logic [spc_pkg::RadW-1:0] r2_i,
  output logic done_o,
  output logic signed [spc_pkg::GapW-1:0] gap_o,
  output logic signed [spc_pkg::CoordW-1:0] contact_x_o,
  output logic signed [spc_pkg::CoordW-1:0] contact_y_o,
  output logic signed [spc_pkg::CoordW-1:0] contact_z_o,
  output logic signed [spc_pkg::NormW-1:0] normal_x_o,
  output logic signed [spc_pkg::NormW-1:0] normal_y_o,
  output logic signed [spc_pkg::NormW-1:0] normal_z_o,
  output logic degenerate_o
);
  import spc_pkg::*;
  localparam int unsigned NumW = 65;            // |r*c| sum magnitude
  localparam int unsigned NDW = DiffW + FRACTION_BITS; // normal dividend
  localparam int unsigned CW = 7;

  st_e st_q, st_d;
  logic [CW-1:0] cnt_q;

  logic signed [DiffW-1:0] d_q [3];
  logic [DiffW-1:0] ad [3];
  logic signed [CoordW-1:0] c1_q [3], c2_q [3];
  logic [SqW-1:0] sum_q;
  logic [DistW-1:0] root_q;
  logic [SqW-1:0] rem_q;
  logic [RadW:0] rsum_q;
  logic [1:0] ax_q;
  logic signed [NumW:0] num_q [3];
  logic [NumW-1:0] nq_q [3], nr_q [3];
  logic [NDW-1:0] dq_q [3];
  logic [DistW:0] dr_q [3];

  always_comb
    for (int i = 0; i < 3; i++)
      ad[i] = d_q[i][DiffW-1] ? DiffW'(-d_q[i]) : d_q[i];

  assign pop_o = st_q == S_IDLE && valid_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (valid_i) st_d = S_SQ;
      S_SQ:   if (ax_q == 2'd2) st_d = S_ROOT;
      S_ROOT: if (cnt_q == '0) st_d = S_DIV;
      S_DIV:  if (cnt_q == '0) st_d = S_OUT;
      S_OUT:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; done_o <= 1'b0;
    end else begin
      st_q <= st_d;
      done_o <= st_q == S_OUT;
    end
  end

  logic [SqW-1:0] trial;
  logic [SqW-1:0] rem_sh;
  always_comb begin
    rem_sh = {rem_q[SqW-3:0], sum_q[2*cnt_q[5:0]+1 -: 2]};
    trial = SqW'({root_q, 2'b01});
  end

  logic degen;
  assign degen = root_q == '0 || rsum_q == '0;

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        c1_q <= '{item_i.c1x, item_i.c1y, item_i.c1z};
        c2_q <= '{item_i.c2x, item_i.c2y, item_i.c2z};
        d_q[0] <= DiffW'(item_i.c1x) - DiffW'(item_i.c2x);
        d_q[1] <= DiffW'(item_i.c1y) - DiffW'(item_i.c2y);
        d_q[2] <= DiffW'(item_i.c1z) - DiffW'(item_i.c2z);
        rsum_q <= {1'b0, r1_i} + {1'b0, r2_i};
        sum_q <= '0; ax_q <= '0;
      end
      S_SQ: begin
        // one squared component per cycle, plus the r*c products
        sum_q <= sum_q + SqW'(ad[ax_q] * ad[ax_q]);
        num_q[ax_q] <= (NumW+1)'($signed({1'b0, r1_i}) * c1_q[ax_q])
                     + (NumW+1)'($signed({1'b0, r2_i}) * c2_q[ax_q]);
        ax_q <= ax_q + 1'b1;
        root_q <= '0; rem_q <= '0; cnt_q <= CW'(DistW - 1);
      end
      S_ROOT: begin
        // restoring root, one bit a cycle
        if (rem_sh >= trial) begin
          rem_q <= rem_sh - trial; root_q <= {root_q[DistW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh; root_q <= {root_q[DistW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_q <= CW'(NumW - 1);
          for (int i = 0; i < 3; i++) begin
            nq_q[i] <= num_q[i][NumW] ? NumW'(-num_q[i]) : num_q[i][NumW-1:0];
            nr_q[i] <= '0;
            dq_q[i] <= NDW'(ad[i]) << FRACTION_BITS;
            dr_q[i] <= '0;
          end
        end
      end
      S_DIV: begin
        // restoring dividers, one bit a cycle, three lanes each
        for (int i = 0; i < 3; i++) begin
          logic [NumW:0] t;
          logic [DistW+1:0] u;
          t = {nr_q[i], nq_q[i][NumW-1]};
          if (t >= (NumW+1)'(rsum_q)) begin
            nr_q[i] <= NumW'(t - (NumW+1)'(rsum_q));
            nq_q[i] <= {nq_q[i][NumW-2:0], 1'b1};
          end else begin
            nr_q[i] <= NumW'(t);
            nq_q[i] <= {nq_q[i][NumW-2:0], 1'b0};
          end
          if (cnt_q < CW'(NDW)) begin
            u = {dr_q[i], dq_q[i][NDW-1]};
            if (u >= (DistW+2)'(root_q)) begin
              dr_q[i] <= (DistW+1)'(u - (DistW+2)'(root_q));
              dq_q[i] <= {dq_q[i][NDW-2:0], 1'b1};
            end else begin
              dr_q[i] <= (DistW+1)'(u);
              dq_q[i] <= {dq_q[i][NDW-2:0], 1'b0};
            end
          end
        end
        cnt_q <= cnt_q - 1'b1;
      end
      S_OUT: begin
        gap_o <= GapW'($signed({1'b0, root_q}) - $signed({2'b0, rsum_q}));
        degenerate_o <= degen;
        begin
          logic signed [CoordW-1:0] p [3];
          logic signed [NormW-1:0] n [3];
          for (int i = 0; i < 3; i++) begin
            logic [NDW:0] q;
            p[i] = num_q[i][NumW] ? CoordW'(-nq_q[i]) : CoordW'(nq_q[i]);
            q = {1'b0, dq_q[i]};
            if (q > (NDW+1)'(131071 + (d_q[i][DiffW-1] ? 1 : 0)))
              n[i] = d_q[i][DiffW-1] ? NormW'(-131072) : NormW'(131071);
            else
              n[i] = d_q[i][DiffW-1] ? NormW'(-q) : NormW'(q);
            if (degen) begin p[i] = '0; n[i] = '0; end
          end
          contact_x_o <= p[0]; contact_y_o <= p[1]; contact_z_o <= p[2];
          normal_x_o <= n[0]; normal_y_o <= n[1]; normal_z_o <= n[2];
        end
      end
      default: ;
    endcase
  end
endmodule

[design/spc_checker.sv]
// port-level checker for the sphere pair contact block
module spc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy_o,
  input logic done_o,
  input logic degenerate_o,
  input logic signed [17:0] normal_x_o,
  input logic signed [31:0] contact_x_o
);
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back results");
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> normal_x_o == '0 && contact_x_o == '0)
    else $error("degenerate result not cleared");
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !done_o && !busy_o) else $error("result or busy during reset");
endmodule

bind sphere_pair_contact spc_checker u_spc_checker (
  .clk_i, .rst_ni, .busy_o, .done_o, .degenerate_o, .normal_x_o, .contact_x_o
);
